@@ design/fpsa_pkg.sv @@
// Shared types and constants of the fit-policy segment allocator.
package fpsa_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int SIZE_BITS_DEF    = 16;

  // Beat field widths
  localparam int KIND_W  = 2;
  localparam int REQ_W   = 16;
  localparam int OWNER_W = 8;
  localparam int RIDX_W  = 5;
  localparam int ERR_W   = 2;
  localparam int POL_W   = 2;

  // Owner characters
  localparam logic [OWNER_W-1:0] HOLE_OWNER   = 8'h30;  // '0'
  localparam logic [OWNER_W-1:0] FIRST_LETTER = 8'h41;  // 'A'

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NOFIT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_INDEX = 2'd3;

  // Fit policies; the unused code behaves as first fit
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  // Result beat, last field in the lowest bits
  typedef struct packed {
    logic [15:0]        remainder_size;
    logic               entry_is_hole;
    logic [15:0]        entry_size;
    logic [OWNER_W-1:0] entry_owner;
    logic [4:0]         entry_index;
    logic [ERR_W-1:0]   error_code;
  } res_t;

  // Verdict of the fit unit on one table entry
  typedef struct packed {
    logic take;  // entry becomes the new pick
    logic stop;  // no later entry can replace it
  } fit_res_t;

endpackage

@@ design/fpsa_seg_mem.sv @@
// Segment table storage: one write port, one read port with registered data.
module fpsa_seg_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 25,
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/fpsa_fit_unit.sv @@
// Shared compare unit: judges one table entry against the request and the current pick.
module fpsa_fit_unit #(
  parameter int SIZE_BITS = 16
) (
  input  logic                        entry_hole,
  input  logic [SIZE_BITS-1:0]        entry_size,
  input  logic [SIZE_BITS-1:0]        req_size,
  input  logic                        pick_valid,
  input  logic [SIZE_BITS-1:0]        pick_size,
  input  logic [fpsa_pkg::POL_W-1:0]  policy,
  output fpsa_pkg::fit_res_t          verdict
);
  import fpsa_pkg::*;

  logic fits;
  logic smaller;
  logic not_smaller;

  assign fits        = entry_hole && (entry_size >= req_size);
  assign smaller     = entry_size < pick_size;
  assign not_smaller = !smaller;

  always_comb begin
    verdict.take = fits && (!pick_valid
                            || ((policy == POL_BEST) && smaller)
                            || ((policy == POL_WORST) && not_smaller));
    // first fit (and the unused code) ends the scan on the first hole that fits
    verdict.stop = fits && !pick_valid && (policy != POL_BEST) && (policy != POL_WORST);
  end

endmodule

@@ design/fit_policy_segment_allocator.sv @@
// Top level of the fit-policy segment allocator: sequencer, table and result register.
//
// Keeps an ordered table of up to MAX_SEGMENTS segments (size, owner character,
// hole mark). Append beats add a segment at the end, allocate beats place a
// request in a hole picked by fit_policy (0 first fit, 1 best fit = first
// smallest, 2 worst fit = last largest, 3 as first fit), read beats return
// one entry. The picked hole shrinks to the request, is owned by the next
// letter from 'A' and any remainder is inserted right after it as a hole
// owned by '0'. Every input beat gives exactly one result beat. The block
// handles one item at a time: s_tready is high only while the sequencer
// idles, but a finished result waits in its own output register, so the next
// item can enter while it is unread. Append and unknown kinds go straight to
// the output state, reads pass through a data state first, and allocations
// scan entries (all of them for best and worst fit, up to the first fitting
// hole for first fit), then, if a remainder is left, move entries up to open
// a slot for it. The table has a registered read port, so each scanned or
// moved entry passes through a read state and then a compare or write state.
// A result still unread in the output register holds the next one in the
// sequencer's final state until it is taken.
// fit_policy is taken on cfg beats at any time; change it only while idle.
module fit_policy_segment_allocator #(
  parameter int MAX_SEGMENTS = fpsa_pkg::MAX_SEGMENTS_DEF,
  parameter int SIZE_BITS    = fpsa_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input item beats
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] request_size, [23:16] owner_name, [24] append_is_hole,
  // [29:25] read_index, [31:30] zero
  input  logic [31:0] s_tdata,
  // [1:0] kind
  input  logic [1:0]  s_tuser,
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] error_code, [6:2] entry_index, [14:7] entry_owner,
  // [30:15] entry_size, [31] entry_is_hole, [47:32] remainder_size
  output logic [47:0] m_tdata,
  // fit_policy register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);
  import fpsa_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int ENT_W = 1 + OWNER_W + SIZE_BITS;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SCAN_RD  = 9'b000000010,
    S_SCAN_CMP = 9'b000000100,
    S_DECIDE   = 9'b000001000,
    S_SHIFT_RD = 9'b000010000,
    S_SHIFT_WR = 9'b000100000,
    S_SPLIT    = 9'b001000000,
    S_RD_DATA  = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  // table entry layout
  typedef struct packed {
    logic                 hole;
    logic [OWNER_W-1:0]   owner;
    logic [SIZE_BITS-1:0] size;
  } entry_t;

  // input beat fields
  logic [KIND_W-1:0]  in_kind;
  logic [REQ_W-1:0]   in_req;
  logic [OWNER_W-1:0] in_owner;
  logic               in_hole;
  logic [RIDX_W-1:0]  in_ridx;
  logic               in_accept;

  assign in_kind   = s_tuser;
  assign in_req    = s_tdata[15:0];
  assign in_owner  = s_tdata[23:16];
  assign in_hole   = s_tdata[24];
  assign in_ridx   = s_tdata[29:25];
  assign in_accept = s_tvalid && s_tready;

  // control state
  state_t             state;
  logic [CNT_W-1:0]   segment_count;
  logic [OWNER_W-1:0] letter;
  logic [POL_W-1:0]   policy;
  logic               pick_valid;

  // working registers
  logic [SIZE_BITS-1:0] req_q;
  logic [SIZE_BITS-1:0] pick_size;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] diff_q;
  logic [CNT_W-1:0]     scan;
  logic [CNT_W-1:0]     src;
  logic [RIDX_W-1:0]    ridx_q;
  res_t                 res;
  res_t                 out_q;

  // table ports
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_rdata;
  entry_t           rd_ent;

  logic                 table_full;
  logic                 read_beyond;
  logic [SIZE_BITS-1:0] diff;
  logic                 shift_more;
  fit_res_t             verdict;

  assign rd_ent      = entry_t'(mem_rdata);
  assign table_full  = segment_count == CNT_W'(MAX_SEGMENTS);
  assign read_beyond = 32'(in_ridx) >= 32'(segment_count);
  assign diff        = pick_size - req_q;
  // another entry to move while the one below the source still lies above the pick
  assign shift_more  = (src - 1'b1) > CNT_W'(pick_idx);

  assign s_tready  = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign m_tdata   = out_q;

  fpsa_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (ENT_W),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  fpsa_fit_unit #(
    .SIZE_BITS (SIZE_BITS)
  ) u_fit (
    .entry_hole (rd_ent.hole),
    .entry_size (rd_ent.size),
    .req_size   (req_q),
    .pick_valid (pick_valid),
    .pick_size  (pick_size),
    .policy     (policy),
    .verdict    (verdict)
  );

  // Read address: the entry under scan, the entry being moved, or the read
  // index of the beat on the input so that its data is ready in the next cycle.
  always_comb begin
    case (state)
      S_SCAN_RD:  mem_raddr = scan[IDX_W-1:0];
      S_SHIFT_RD: mem_raddr = src[IDX_W-1:0];
      default:    mem_raddr = IDX_W'(in_ridx);
    endcase
  end

  // Write port: append at the end, shrink the pick, move an entry up, or
  // place the remainder hole.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = segment_count[IDX_W-1:0];
    mem_wdata = '{hole: in_hole, owner: in_owner, size: SIZE_BITS'(in_req)};
    case (state)
      S_IDLE: begin
        mem_we = in_accept && (in_kind == KIND_APPEND) && !table_full;
      end
      S_DECIDE: begin
        mem_we    = pick_valid && !((diff != '0) && table_full);
        mem_waddr = pick_idx;
        mem_wdata = '{hole: 1'b0, owner: letter, size: req_q};
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(src + 1'b1);
        mem_wdata = rd_ent;
      end
      S_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = pick_idx + 1'b1;
        mem_wdata = '{hole: 1'b1, owner: HOLE_OWNER, size: diff_q};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      segment_count <= '0;
      letter        <= FIRST_LETTER;
      policy        <= POL_FIRST;
      pick_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        policy <= cfg_data;
      end
      // drop valid once taken, unless a new result replaces it this cycle
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (in_kind)
              KIND_APPEND: begin
                if (table_full) begin
                  res <= '{error_code: ERR_FULL, entry_index: '0, entry_owner: '0,
                           entry_size: '0, entry_is_hole: 1'b0, remainder_size: '0};
                end else begin
                  segment_count <= segment_count + 1'b1;
                  res <= '{error_code: ERR_OK, entry_index: 5'(segment_count),
                           entry_owner: in_owner, entry_size: 16'(SIZE_BITS'(in_req)),
                           entry_is_hole: in_hole, remainder_size: '0};
                end
                state <= S_OUT;
              end
              KIND_ALLOC: begin
                req_q      <= SIZE_BITS'(in_req);
                scan       <= '0;
                pick_valid <= 1'b0;
                state      <= S_SCAN_RD;
              end
              KIND_READ: begin
                ridx_q <= in_ridx;
                if (read_beyond) begin
                  res   <= '{error_code: ERR_INDEX, entry_index: in_ridx, entry_owner: '0,
                             entry_size: '0, entry_is_hole: 1'b0, remainder_size: '0};
                  state <= S_OUT;
                end else begin
                  state <= S_RD_DATA;
                end
              end
              default: begin
                res   <= '0;
                state <= S_OUT;
              end
            endcase
          end
        end

        S_RD_DATA: begin
          res   <= '{error_code: ERR_OK, entry_index: ridx_q, entry_owner: rd_ent.owner,
                     entry_size: 16'(rd_ent.size), entry_is_hole: rd_ent.hole,
                     remainder_size: '0};
          state <= S_OUT;
        end

        S_SCAN_RD: begin
          // scan ends at the count; the read for this entry lands next cycle
          if (scan == segment_count) begin
            state <= S_DECIDE;
          end else begin
            state <= S_SCAN_CMP;
          end
        end

        S_SCAN_CMP: begin
          if (verdict.take) begin
            pick_valid <= 1'b1;
            pick_idx   <= scan[IDX_W-1:0];
            pick_size  <= rd_ent.size;
          end
          scan <= scan + 1'b1;
          if (verdict.stop) begin
            state <= S_DECIDE;
          end else begin
            state <= S_SCAN_RD;
          end
        end

        S_DECIDE: begin
          if (!pick_valid) begin
            res   <= '{error_code: ERR_NOFIT, entry_index: '0, entry_owner: '0,
                       entry_size: '0, entry_is_hole: 1'b0, remainder_size: '0};
            state <= S_OUT;
          end else if ((diff != '0) && table_full) begin
            res   <= '{error_code: ERR_FULL, entry_index: '0, entry_owner: '0,
                       entry_size: '0, entry_is_hole: 1'b0, remainder_size: '0};
            state <= S_OUT;
          end else begin
            res    <= '{error_code: ERR_OK, entry_index: 5'(pick_idx), entry_owner: letter,
                        entry_size: 16'(req_q), entry_is_hole: 1'b0,
                        remainder_size: 16'(diff)};
            letter <= letter + 1'b1;
            diff_q <= diff;
            src    <= segment_count - 1'b1;
            if (diff == '0) begin
              state <= S_OUT;
            end else if ((segment_count - 1'b1) > CNT_W'(pick_idx)) begin
              state <= S_SHIFT_RD;
            end else begin
              state <= S_SPLIT;
            end
          end
        end

        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end

        S_SHIFT_WR: begin
          // entry src moves to src + 1; walk down towards the pick
          src <= src - 1'b1;
          if (shift_more) begin
            state <= S_SHIFT_RD;
          end else begin
            state <= S_SPLIT;
          end
        end

        S_SPLIT: begin
          segment_count <= segment_count + 1'b1;
          state         <= S_OUT;
        end

        S_OUT: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            out_q    <= res;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(segment_count) <= MAX_SEGMENTS)
    else $error("segment count beyond table depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) <= 32'(segment_count)))
    else $error("table write beyond the end of the table");

  a_shift_above_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_WR) |-> (src > CNT_W'(pick_idx)))
    else $error("entry move reached the picked hole");

  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CMP) |-> (scan < segment_count))
    else $error("scan compared an entry beyond the count");

  a_letter_on_alloc: assert property (@(posedge clk) disable iff (rst)
    !$stable(letter) |-> $past(state == S_DECIDE))
    else $error("owner letter advanced outside an allocation");
`endif

endmodule
